FILE: src/cdmp_pkg.sv
// Shared widths, constants, tables and payload types of the date step-back pipeline.
`default_nettype none

package cdmp_pkg;

    localparam int DAY_BITS = 21;

    // Calendar constants of the era-based civil date conversion.
    localparam int ERA_DAYS    = 146097;
    localparam int EPOCH_SHIFT = 719468;
    localparam int CENT_DAYS   = 36524;

    // Biased serial width: the bias makes the era split work on a non-negative value.
    localparam int XW = (DAY_BITS >= 20) ? DAY_BITS + 1 : 21;
    localparam int QW = XW - 17;
    localparam int EW = QW + 2;
    localparam int SW = XW + 1;

    localparam longint ERA_BIAS = (longint'(1) << (DAY_BITS - 1)) / ERA_DAYS + 1;
    localparam longint X_OFFSET = EPOCH_SHIFT + ERA_BIAS * ERA_DAYS;
    localparam longint DAY_MIN  = -(longint'(1) << (DAY_BITS - 1));

    // Era estimate: the low bits are dropped, the rest is scaled by a reciprocal.
    localparam int     XH_SHIFT  = 10;
    localparam int     XHW       = XW - XH_SHIFT;
    localparam int     ERA_RS    = 32;
    localparam int     ERA_RW    = 25;
    localparam longint ERA_RECIP = (longint'(1) << (XH_SHIFT + ERA_RS)) / ERA_DAYS;
    localparam int     QPW       = XHW + ERA_RW;

    localparam int REM_W = 19;
    localparam int DOE_W = 18;

    // Exact reciprocals for division by small constants over a bounded input range.
    localparam int     K1460 = 29;
    localparam longint M1460 = ((longint'(1) << K1460) + 1459) / 1460;
    localparam int     P1_W  = 37;
    localparam int     K365  = 27;
    localparam longint M365  = ((longint'(1) << K365) + 364) / 365;
    localparam int     P2_W  = 37;
    localparam int     K153  = 19;
    localparam longint M153  = ((longint'(1) << K153) + 152) / 153;
    localparam int     P3_W  = 23;
    localparam int     K12   = 16;
    localparam longint M12   = ((longint'(1) << K12) + 11) / 12;
    localparam int     CQP_W = 25;

    typedef enum logic [1:0] {
        KIND_DAYS   = 2'd0,
        KIND_WEEKS  = 2'd1,
        KIND_MONTHS = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    // Civil date of the start serial, with the month count already split into years and months.
    typedef struct packed {
        logic [EW-1:0] era;
        logic [8:0]    yoe;
        logic [3:0]    mm;
        logic [4:0]    day;
        logic [8:0]    cq;
        logic [3:0]    cr;
    } split_t;

    // Target date: era, year of era, month 1 to 12 and clamped day.
    typedef struct packed {
        logic [EW-1:0] era;
        logic [8:0]    yoe;
        logic [3:0]    mon;
        logic [4:0]    day;
    } civil_t;

    // Target serial in two parts that the last stage adds.
    typedef struct packed {
        logic [SW-1:0]    era_days;
        logic [DOE_W-1:0] doe;
    } join_t;

    // First day of each month, counted from the first of March.
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] days;
        unique case (mp)
            4'd0:    days = 9'd0;
            4'd1:    days = 9'd31;
            4'd2:    days = 9'd61;
            4'd3:    days = 9'd92;
            4'd4:    days = 9'd122;
            4'd5:    days = 9'd153;
            4'd6:    days = 9'd184;
            4'd7:    days = 9'd214;
            4'd8:    days = 9'd245;
            4'd9:    days = 9'd275;
            4'd10:   days = 9'd306;
            4'd11:   days = 9'd337;
            default: days = 9'd0;
        endcase
        return days;
    endfunction

    function automatic logic [1:0] century_of(input logic [8:0] yoe);
        logic [1:0] c;
        priority if (yoe >= 9'd300) begin
            c = 2'd3;
        end else if (yoe >= 9'd200) begin
            c = 2'd2;
        end else if (yoe >= 9'd100) begin
            c = 2'd1;
        end else begin
            c = 2'd0;
        end
        return c;
    endfunction

    // Days from the start of the era to the first of March of the given year of era.
    function automatic logic [DOE_W-1:0] years_days(input logic [8:0] yoe);
        return DOE_W'(yoe) * DOE_W'(365) + DOE_W'(yoe >> 2) - DOE_W'(century_of(yoe));
    endfunction

endpackage

`default_nettype wire

FILE: src/cdmp_split.sv
// Nine-stage split of a day serial into era, year of era, month and day.
`default_nettype none

module cdmp_split
    import cdmp_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic [8:0]                 stage_en,
    input  wire logic signed [DAY_BITS-1:0] day_serial,
    input  wire logic [11:0]                period_count,
    output split_t                          civil
);

    typedef struct packed {
        logic [EW-1:0] era;
        logic [8:0]    cq;
        logic [3:0]    cr;
    } carry_t;

    // Stage 0: biased serial and count.
    logic signed [XW:0] x_wide;
    logic [XW-1:0]      x_next;
    logic [XW-1:0]      x0_reg;
    logic [11:0]        cnt0_reg;

    // Stage 1: era estimate and month count split products.
    logic [QPW-1:0]   qp_next;
    logic [QPW-1:0]   qp_reg;
    logic [XW-1:0]    x1_reg;
    logic [CQP_W-1:0] cqp_next;
    logic [CQP_W-1:0] cqp_reg;
    logic [11:0]      cnt1_reg;

    // Stage 2: estimate and its remainder.
    logic [QW-1:0]    q_est;
    logic [XW-1:0]    rem_wide;
    logic [REM_W-1:0] rem_next;
    logic [8:0]       cq_next;
    logic [11:0]      cr_wide;
    logic [3:0]       cr_next;
    logic [QW-1:0]    q2_reg;
    logic [REM_W-1:0] rem2_reg;
    logic [8:0]       cq2_reg;
    logic [3:0]       cr2_reg;

    // Stage 3: corrected era and day of era.
    logic             over;
    logic [QW-1:0]    q_fix;
    logic [DOE_W-1:0] doe_next;
    logic [2:0]       cent_next;
    logic             last_next;
    carry_t           carry_next;
    logic [DOE_W-1:0] doe3_reg;
    logic [2:0]       cent3_reg;
    logic             last3_reg;
    carry_t           carry_reg [3:7];

    // Stage 4.
    logic [P1_W-1:0]  p1_next;
    logic [P1_W-1:0]  p1_reg;
    logic [DOE_W-1:0] doe4_reg;
    logic [2:0]       cent4_reg;
    logic             last4_reg;

    // Stage 5.
    logic [DOE_W-1:0] a_next;
    logic [P2_W-1:0]  p2_next;
    logic [P2_W-1:0]  p2_reg;
    logic [DOE_W-1:0] doe5_reg;

    // Stage 6.
    logic [8:0]       yoe_next;
    logic [DOE_W-1:0] doy_wide;
    logic [8:0]       doy_next;
    logic [8:0]       yoe6_reg;
    logic [8:0]       doy6_reg;

    // Stage 7.
    logic [10:0]     n_next;
    logic [P3_W-1:0] p3_next;
    logic [P3_W-1:0] p3_reg;
    logic [8:0]      yoe7_reg;
    logic [8:0]      doy7_reg;

    // Stage 8.
    logic [3:0] mp;
    logic [8:0] day_wide;
    logic [3:0] mm_next;
    split_t     civ_next;
    split_t     civ_reg;

    assign x_wide = (XW + 1)'(day_serial) + (XW + 1)'(X_OFFSET);
    assign x_next = x_wide[XW-1:0];

    assign qp_next  = QPW'(x0_reg[XW-1:XH_SHIFT]) * QPW'(ERA_RECIP);
    assign cqp_next = CQP_W'(cnt0_reg) * CQP_W'(M12);

    // The estimate is the true quotient or one less.
    assign q_est    = qp_reg[ERA_RS +: QW];
    assign rem_wide = x1_reg - XW'(q_est) * XW'(ERA_DAYS);
    assign rem_next = rem_wide[REM_W-1:0];
    assign cq_next  = cqp_reg[K12 +: 9];
    assign cr_wide  = cnt1_reg - 12'(cq_next) * 12'(12);
    assign cr_next  = cr_wide[3:0];

    assign over     = rem2_reg >= REM_W'(ERA_DAYS);
    assign q_fix    = q2_reg + QW'(over);
    assign doe_next = over ? DOE_W'(rem2_reg - REM_W'(ERA_DAYS)) : DOE_W'(rem2_reg);
    assign last_next = doe_next == DOE_W'(4 * CENT_DAYS);

    always_comb begin
        priority if (doe_next >= DOE_W'(4 * CENT_DAYS)) begin
            cent_next = 3'd4;
        end else if (doe_next >= DOE_W'(3 * CENT_DAYS)) begin
            cent_next = 3'd3;
        end else if (doe_next >= DOE_W'(2 * CENT_DAYS)) begin
            cent_next = 3'd2;
        end else if (doe_next >= DOE_W'(CENT_DAYS)) begin
            cent_next = 3'd1;
        end else begin
            cent_next = 3'd0;
        end
    end

    assign carry_next = '{era: EW'(q_fix) - EW'(ERA_BIAS), cq: cq2_reg, cr: cr2_reg};

    assign p1_next = P1_W'(doe3_reg) * P1_W'(M1460);

    assign a_next  = doe4_reg - DOE_W'(p1_reg[K1460 +: 7]) + DOE_W'(cent4_reg)
                   - DOE_W'(last4_reg);
    assign p2_next = P2_W'(a_next) * P2_W'(M365);

    assign yoe_next = p2_reg[K365 +: 9];
    assign doy_wide = doe5_reg - years_days(yoe_next);
    assign doy_next = doy_wide[8:0];

    assign n_next  = (11'(doy6_reg) << 2) + 11'(doy6_reg) + 11'd2;
    assign p3_next = P3_W'(n_next) * P3_W'(M153);

    assign mp       = p3_reg[K153 +: 4];
    assign day_wide = doy7_reg - month_start(mp) + 9'd1;
    assign mm_next  = (mp < 4'd10) ? mp + 4'd3 : mp - 4'd9;
    assign civ_next = '{era: carry_reg[7].era, yoe: yoe7_reg, mm: mm_next,
                        day: day_wide[4:0], cq: carry_reg[7].cq, cr: carry_reg[7].cr};

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            x0_reg   <= x_next;
            cnt0_reg <= period_count;
        end
        if (stage_en[1]) begin
            qp_reg   <= qp_next;
            x1_reg   <= x0_reg;
            cqp_reg  <= cqp_next;
            cnt1_reg <= cnt0_reg;
        end
        if (stage_en[2]) begin
            q2_reg   <= q_est;
            rem2_reg <= rem_next;
            cq2_reg  <= cq_next;
            cr2_reg  <= cr_next;
        end
        if (stage_en[3]) begin
            doe3_reg     <= doe_next;
            cent3_reg    <= cent_next;
            last3_reg    <= last_next;
            carry_reg[3] <= carry_next;
        end
        if (stage_en[4]) begin
            p1_reg    <= p1_next;
            doe4_reg  <= doe3_reg;
            cent4_reg <= cent3_reg;
            last4_reg <= last3_reg;
        end
        if (stage_en[5]) begin
            p2_reg   <= p2_next;
            doe5_reg <= doe4_reg;
        end
        if (stage_en[6]) begin
            yoe6_reg <= yoe_next;
            doy6_reg <= doy_next;
        end
        if (stage_en[7]) begin
            p3_reg   <= p3_next;
            yoe7_reg <= yoe6_reg;
            doy7_reg <= doy6_reg;
        end
        for (int i = 4; i <= 7; i++) begin
            if (stage_en[i]) begin
                carry_reg[i] <= carry_reg[i-1];
            end
        end
        if (stage_en[8]) begin
            civ_reg <= civ_next;
        end
    end

    assign civil = civ_reg;

endmodule

`default_nettype wire

FILE: src/cdmp_step.sv
// Two-stage month step-back with year-of-era wrap and end-of-month clamp.
`default_nettype none

module cdmp_step
    import cdmp_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic [1:0]   stage_en,
    input  wire split_t       civil,
    output civil_t            target
);

    logic               adj;
    logic signed [5:0]  m0;
    logic [3:0]         nmi_next;
    logic signed [10:0] t_next;
    logic signed [10:0] t_reg;
    logic [3:0]         nmi_reg;
    logic [4:0]         day_reg;
    logic [EW-1:0]      era_reg;

    logic [8:0]    ty;
    logic [EW-1:0] era_fix;
    logic [3:0]    nm;
    logic          leap;
    logic [4:0]    last;
    civil_t        tgt_next;
    civil_t        tgt_reg;

    // January and February belong to the next year of the March-based era.
    assign adj      = civil.mm <= 4'd2;
    assign m0       = $signed({2'b00, civil.mm}) - 6'sd1 - $signed({2'b00, civil.cr});
    assign nmi_next = m0[5] ? 4'(m0 + 6'sd12) : 4'(m0);
    assign t_next   = $signed({2'b00, civil.yoe}) + $signed({10'b0, adj})
                    - $signed({2'b00, civil.cq}) - $signed({10'b0, m0[5]});

    always_comb begin
        priority if (t_reg < 11'sd0) begin
            ty      = 9'(t_reg + 11'sd400);
            era_fix = era_reg - EW'(1);
        end else if (t_reg >= 11'sd400) begin
            ty      = 9'(t_reg - 11'sd400);
            era_fix = era_reg + EW'(1);
        end else begin
            ty      = 9'(t_reg);
            era_fix = era_reg;
        end
    end

    assign nm   = nmi_reg + 4'd1;
    // Leap years repeat every 400 years, so the year of era decides.
    assign leap = (ty[1:0] == 2'b00) && (ty != 9'd100) && (ty != 9'd200) && (ty != 9'd300);

    always_comb begin
        unique case (nm)
            4'd2:                         last = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:      last = 5'd30;
            default:                      last = 5'd31;
        endcase
    end

    assign tgt_next = '{era: era_fix, yoe: ty, mon: nm,
                        day: (day_reg > last) ? last : day_reg};

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            t_reg   <= t_next;
            nmi_reg <= nmi_next;
            day_reg <= civil.day;
            era_reg <= civil.era;
        end
        if (stage_en[1]) begin
            tgt_reg <= tgt_next;
        end
    end

    assign target = tgt_reg;

endmodule

`default_nettype wire

FILE: src/cdmp_join.sv
// Two-stage conversion of the target civil date back to its day serial parts.
`default_nettype none

module cdmp_join
    import cdmp_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic [1:0] stage_en,
    input  wire civil_t     target,
    output join_t           serial
);

    logic          below;
    logic [8:0]    yoe_next;
    logic [EW-1:0] era_next;
    logic [3:0]    mp;
    logic [8:0]    doy_next;
    logic [EW-1:0] era_reg;
    logic [8:0]    yoe_reg;
    logic [8:0]    doy_reg;

    logic signed [EW+18:0] era_prod;
    join_t                 join_next;
    join_t                 join_reg;

    // January and February count in the previous March-based year.
    assign below = target.mon <= 4'd2;

    always_comb begin
        if (below && (target.yoe == 9'd0)) begin
            yoe_next = 9'd399;
            era_next = target.era - EW'(1);
        end else begin
            yoe_next = target.yoe - 9'(below);
            era_next = target.era;
        end
    end

    assign mp       = below ? target.mon + 4'd9 : target.mon - 4'd3;
    assign doy_next = month_start(mp) + 9'(target.day) - 9'd1;

    assign era_prod  = $signed(era_reg) * $signed(19'(ERA_DAYS));
    assign join_next = '{era_days: SW'(era_prod), doe: years_days(yoe_reg) + DOE_W'(doy_reg)};

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            era_reg <= era_next;
            yoe_reg <= yoe_next;
            doy_reg <= doy_next;
        end
        if (stage_en[1]) begin
            join_reg <= join_next;
        end
    end

    assign serial = join_reg;

endmodule

`default_nettype wire

FILE: src/calendar_date_minus_period.sv
// Top level of the date step-back pipeline: a date minus days, weeks or months.
//
// Input channel s_: a start date as a signed day serial (days since 1970-01-01,
// proleptic Gregorian), a period kind (days, weeks, months; the fourth code passes
// the date through) and a count of periods. Output channel m_: the date that many
// periods earlier and an underflow flag, set when the true date lies below the serial
// range and the result has been saturated to the lowest serial.
// Both channels use valid and ready; a word moves when both are high.
// The block is a fourteen-stage pipeline, and one word is accepted every cycle while
// the receiver takes the results.
// The depth is set by the month path, which splits the serial into era, year, month
// and day with reciprocal multiplications, steps and clamps the month, and joins
// the date back; days and weeks travel alongside it in a delay line.
// Each stage has its own valid bit, so when the receiver stalls, empty stages keep
// filling and s_ready only falls once the pipeline is full; nothing is lost.
// Reset (aresetn low at a clock edge) empties the pipeline; there is no other state.
`default_nettype none

module calendar_date_minus_period
    import cdmp_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic signed [DAY_BITS-1:0] s_day_serial,
    input  wire logic [1:0]                 s_kind,
    input  wire logic [11:0]                s_period_count,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic signed [DAY_BITS-1:0]      m_result_day,
    output logic                            m_underflow
);

    localparam int STAGES = 14;
    localparam int LAST   = STAGES - 1;

    logic [STAGES-1:0] v_reg;
    logic [STAGES-1:0] v_next;
    logic [STAGES-1:0] stage_en;

    logic signed [SW-1:0] start_w;
    logic [SW-1:0]        weeks_w;
    logic signed [SW-1:0] lin_next;
    logic                 month_next;
    logic signed [SW-1:0] lin_reg   [0:LAST-1];
    logic                 month_reg [0:LAST-1];

    split_t civil;
    civil_t target;
    join_t  serial;

    logic signed [SW-1:0]       res_month;
    logic signed [SW-1:0]       res;
    logic                       uf_next;
    logic signed [DAY_BITS-1:0] day_next;
    logic signed [DAY_BITS-1:0] day_reg;
    logic                       uf_reg;

    // A stage may load when it is empty or when the stage after it moves on.
    always_comb begin
        stage_en[LAST] = !v_reg[LAST] || m_ready;
        for (int i = LAST - 1; i >= 0; i--) begin
            stage_en[i] = !v_reg[i] || stage_en[i+1];
        end
    end

    always_comb begin
        v_next = v_reg;
        if (stage_en[0]) begin
            v_next[0] = s_valid;
        end
        for (int i = 1; i < STAGES; i++) begin
            if (stage_en[i]) begin
                v_next[i] = v_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    assign s_ready = stage_en[0];

    // Days and weeks subtract at once; the result waits beside the month path.
    assign start_w = SW'(s_day_serial);
    assign weeks_w = SW'({s_period_count, 3'b000}) - SW'(s_period_count);

    always_comb begin
        unique case (kind_t'(s_kind))
            KIND_DAYS:   lin_next = start_w - $signed(SW'(s_period_count));
            KIND_WEEKS:  lin_next = start_w - $signed(weeks_w);
            KIND_MONTHS: lin_next = start_w;
            KIND_NONE:   lin_next = start_w;
            default:     lin_next = start_w;
        endcase
    end

    assign month_next = kind_t'(s_kind) == KIND_MONTHS;

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            lin_reg[0]   <= lin_next;
            month_reg[0] <= month_next;
        end
        for (int i = 1; i < LAST; i++) begin
            if (stage_en[i]) begin
                lin_reg[i]   <= lin_reg[i-1];
                month_reg[i] <= month_reg[i-1];
            end
        end
    end

    cdmp_split u_split (
        .aclk         (aclk),
        .stage_en     (stage_en[8:0]),
        .day_serial   (s_day_serial),
        .period_count (s_period_count),
        .civil        (civil)
    );

    cdmp_step u_step (
        .aclk     (aclk),
        .stage_en (stage_en[10:9]),
        .civil    (civil),
        .target   (target)
    );

    cdmp_join u_join (
        .aclk     (aclk),
        .stage_en (stage_en[12:11]),
        .target   (target),
        .serial   (serial)
    );

    assign res_month = $signed(serial.era_days) + $signed(SW'(serial.doe))
                     - $signed(SW'(EPOCH_SHIFT));
    assign res       = month_reg[LAST-1] ? res_month : lin_reg[LAST-1];
    assign uf_next   = res < SW'(DAY_MIN);
    assign day_next  = uf_next ? DAY_BITS'(DAY_MIN) : res[DAY_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (stage_en[LAST]) begin
            day_reg <= day_next;
            uf_reg  <= uf_next;
        end
    end

    assign m_valid      = v_reg[LAST];
    assign m_result_day = day_reg;
    assign m_underflow  = uf_reg;

`ifndef NO_ASSERTIONS
    // With the output register empty, every stage can move, so the input is open.
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled while the output register was empty");

    // A saturated result always carries the lowest serial.
    a_underflow_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_underflow) |-> (m_result_day == DAY_BITS'(DAY_MIN)))
        else $error("underflow flagged without a saturated result");

    // A word in the last inner stage reaches the output once the output can take it.
    a_last_stage_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (v_reg[LAST-1] && (!m_valid || m_ready)) |=> m_valid)
        else $error("word lost between the last stage and the output register");
`endif

endmodule

`default_nettype wire
